FILE: rtl/core/tmi_pkg.sv
// Shared constants, codes, item types and memory request types for the tape machine interpreter.
package tmi_pkg;

    localparam int PROG_DEPTH  = 4096;
    localparam int TAPE_CELLS  = 30000;
    localparam int STACK_DEPTH = 64;

    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int TAPE_AW = $clog2(TAPE_CELLS);
    localparam int FILL_W  = $clog2(TAPE_CELLS + 1);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    localparam int ADDR_W = 12;
    localparam int PC_W   = 13;
    localparam int CFG_W  = 13;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_STEP    = 2'd2;

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOOPEN   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]      status;
        logic            out_valid;
        logic [7:0]      out_byte;
        logic            input_taken;
        logic [PC_W-1:0] program_counter;
    } res_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic               we;
        logic [PROG_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [PROG_AW-1:0] raddr;
    } prog_req_t;

    typedef struct packed {
        logic               we;
        logic [TAPE_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic [TAPE_AW-1:0] raddr;
    } tape_req_t;

    typedef struct packed {
        logic               we;
        logic [STK_AW-1:0]  waddr;
        logic [PROG_AW-1:0] wdata;
        logic [STK_AW-1:0]  raddr;
    } stk_req_t;

endpackage

FILE: rtl/core/tape_machine_interpreter_top.sv
// An item is captured in S_IDLE and its result registered in S_EXEC once the result slot is free.
// A new item is taken only in S_IDLE, after the last result is registered; all RAMs have registered reads.
// A '[' skip on a zero cell scans the program in S_SCAN for the matching ']', then registers its
//   result in S_RESP; if no ']' closes the loop, the program counter moves to the program end.
// Reset: control, pointer, counter, depth and status clear at once; memories are not swept,
//   the tape reads as zero past a fill count that restart also clears.
module tape_machine_interpreter_top import tmi_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             res_valid,
    input  logic             res_ready,
    output res_item_t        res_item,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    prog_req_t          prog_req;
    tape_req_t          tape_req;
    stk_req_t           stk_req;
    logic [7:0]         prog_rdata;
    logic [7:0]         tape_rdata;
    logic [PROG_AW-1:0] stk_rdata;

    tmi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .prog_req   (prog_req),
        .prog_rdata (prog_rdata),
        .tape_req   (tape_req),
        .tape_rdata (tape_rdata),
        .stk_req    (stk_req),
        .stk_rdata  (stk_rdata)
    );

    tmi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
        .clk   (clk),
        .we    (prog_req.we),
        .waddr (prog_req.waddr),
        .wdata (prog_req.wdata),
        .raddr (prog_req.raddr),
        .rdata (prog_rdata)
    );

    tmi_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape_ram (
        .clk   (clk),
        .we    (tape_req.we),
        .waddr (tape_req.waddr),
        .wdata (tape_req.wdata),
        .raddr (tape_req.raddr),
        .rdata (tape_rdata)
    );

    tmi_ram #(.WIDTH(PROG_AW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stk_req.we),
        .waddr (stk_req.waddr),
        .wdata (stk_req.wdata),
        .raddr (stk_req.raddr),
        .rdata (stk_rdata)
    );

endmodule

FILE: rtl/core/tmi_ram.sv
// Generic simple dual-port RAM with registered read.
module tmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/tmi_ctrl.sv
// Sequencer: item intake, instruction decode, tape/stack read-modify-write, bracket scan, result register.
module tmi_ctrl import tmi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output res_item_t          res_item,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output prog_req_t          prog_req,
    input  logic [7:0]         prog_rdata,
    output tape_req_t          tape_req,
    input  logic [7:0]         tape_rdata,
    output stk_req_t           stk_req,
    input  logic [PROG_AW-1:0] stk_rdata
);

    state_t              state_reg, state_next;
    in_item_t            item_reg, item_next;
    logic [TAPE_AW-1:0]  ptr_reg, ptr_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [2:0]          status_reg, status_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [CFG_W-1:0]    plen_reg;
    logic [PC_W-1:0]     scan_issue_reg, scan_issue_next;
    logic [PC_W-1:0]     scan_chk_reg, scan_chk_next;
    logic                scan_vld_reg, scan_vld_next;
    logic [PC_W-1:0]     nest_reg, nest_next;
    logic                res_valid_reg, res_valid_next;
    res_item_t           res_item_reg, res_item_next;

    logic [PC_W-1:0]     act_len;
    logic [PC_W-1:0]     pc_inc;
    logic [PC_W-1:0]     scan_hit_pc;
    logic [7:0]          cur_cell;
    logic [DEPTH_W-1:0]  depth_dec;
    logic                res_free;
    logic                res_load;
    logic                adv;
    logic                found;
    logic                r_ov;
    logic [7:0]          r_ob;
    logic                r_it;

    assign act_len     = (plen_reg > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : plen_reg;
    assign pc_inc      = pc_reg + PC_W'(1);
    assign scan_hit_pc = scan_chk_reg + PC_W'(1);
    // cells at or past the fill count were not touched since restart
    assign cur_cell    = (FILL_W'(ptr_reg) < fill_reg) ? tape_rdata : 8'd0;
    assign depth_dec   = depth_reg - DEPTH_W'(1);
    assign res_free    = !res_valid_reg || res_ready;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        ptr_next        = ptr_reg;
        pc_next         = pc_reg;
        depth_next      = depth_reg;
        status_next     = status_reg;
        fill_next       = fill_reg;
        scan_issue_next = scan_issue_reg;
        scan_chk_next   = scan_chk_reg;
        scan_vld_next   = scan_vld_reg;
        nest_next       = nest_reg;
        res_load        = 1'b0;
        adv             = 1'b0;
        found           = 1'b0;
        r_ov            = 1'b0;
        r_ob            = 8'd0;
        r_it            = 1'b0;

        prog_req.we    = 1'b0;
        prog_req.waddr = PROG_AW'(item_reg.address);
        prog_req.wdata = item_reg.data_byte;
        prog_req.raddr = (state_reg == S_SCAN) ? scan_issue_reg[PROG_AW-1:0]
                                               : pc_reg[PROG_AW-1:0];
        tape_req.we    = 1'b0;
        tape_req.waddr = ptr_reg;
        tape_req.wdata = cur_cell;
        tape_req.raddr = ptr_reg;
        stk_req.we     = 1'b0;
        stk_req.waddr  = depth_reg[STK_AW-1:0];
        stk_req.wdata  = pc_reg[PROG_AW-1:0];
        stk_req.raddr  = depth_dec[STK_AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (item_reg.op)
                        OP_LOAD:
                        begin
                            prog_req.we = (PC_W'(item_reg.address) < PC_W'(PROG_DEPTH));
                        end
                        OP_RESTART:
                        begin
                            ptr_next    = '0;
                            pc_next     = '0;
                            depth_next  = '0;
                            status_next = ST_RUNNING;
                            fill_next   = '0;
                        end
                        OP_STEP:
                        begin
                            if (status_reg == ST_RUNNING)
                            begin
                                if (pc_reg >= act_len)
                                begin
                                    status_next = ST_DONE;
                                end
                                else
                                begin
                                    tape_req.we = 1'b1;
                                    if (FILL_W'(ptr_reg) == fill_reg)
                                    begin
                                        fill_next = fill_reg + FILL_W'(1);
                                    end
                                    pc_next = pc_inc;
                                    adv     = 1'b1;
                                    unique case (prog_rdata)
                                        CH_LT:
                                        begin
                                            if (ptr_reg == '0)
                                            begin
                                                status_next = ST_RANGE;
                                                pc_next     = pc_reg;
                                                adv         = 1'b0;
                                            end
                                            else
                                            begin
                                                ptr_next = ptr_reg - TAPE_AW'(1);
                                            end
                                        end
                                        CH_GT:
                                        begin
                                            if (ptr_reg >= TAPE_AW'(TAPE_CELLS - 1))
                                            begin
                                                status_next = ST_RANGE;
                                                pc_next     = pc_reg;
                                                adv         = 1'b0;
                                            end
                                            else
                                            begin
                                                ptr_next = ptr_reg + TAPE_AW'(1);
                                            end
                                        end
                                        CH_PLUS:
                                        begin
                                            tape_req.wdata = cur_cell + 8'd1;
                                        end
                                        CH_MINUS:
                                        begin
                                            tape_req.wdata = cur_cell - 8'd1;
                                        end
                                        CH_DOT:
                                        begin
                                            r_ov = 1'b1;
                                            r_ob = cur_cell;
                                        end
                                        CH_COMMA:
                                        begin
                                            tape_req.wdata = item_reg.data_byte;
                                            r_it           = 1'b1;
                                        end
                                        CH_OPEN:
                                        begin
                                            if (cur_cell != 8'd0)
                                            begin
                                                if (depth_reg >= DEPTH_W'(STACK_DEPTH))
                                                begin
                                                    status_next = ST_OVERFLOW;
                                                    pc_next     = pc_reg;
                                                    adv         = 1'b0;
                                                end
                                                else
                                                begin
                                                    stk_req.we = 1'b1;
                                                    depth_next = depth_reg + DEPTH_W'(1);
                                                end
                                            end
                                            else
                                            begin
                                                // skip forward to the matching close
                                                res_load        = 1'b0;
                                                adv             = 1'b0;
                                                pc_next         = pc_reg;
                                                state_next      = S_SCAN;
                                                scan_issue_next = pc_inc;
                                                scan_vld_next   = 1'b0;
                                                nest_next       = '0;
                                            end
                                        end
                                        CH_CLOSE:
                                        begin
                                            if (depth_reg == '0)
                                            begin
                                                status_next = ST_NOOPEN;
                                                pc_next     = pc_reg;
                                                adv         = 1'b0;
                                            end
                                            else if (cur_cell == 8'd0)
                                            begin
                                                depth_next = depth_dec;
                                            end
                                            else
                                            begin
                                                pc_next = PC_W'(stk_rdata) + PC_W'(1);
                                            end
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                    if (adv && (pc_next >= act_len))
                                    begin
                                        status_next = ST_DONE;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_vld_reg)
                begin
                    if (prog_rdata == CH_OPEN)
                    begin
                        nest_next = nest_reg + PC_W'(1);
                    end
                    else if (prog_rdata == CH_CLOSE)
                    begin
                        if (nest_reg == '0)
                        begin
                            found = 1'b1;
                        end
                        else
                        begin
                            nest_next = nest_reg - PC_W'(1);
                        end
                    end
                end
                scan_chk_next = scan_issue_reg;
                scan_vld_next = (scan_issue_reg < act_len);
                if (scan_issue_reg < act_len)
                begin
                    scan_issue_next = scan_issue_reg + PC_W'(1);
                end
                if (found)
                begin
                    pc_next       = scan_hit_pc;
                    status_next   = (scan_hit_pc >= act_len) ? ST_DONE : ST_RUNNING;
                    scan_vld_next = 1'b0;
                    state_next    = S_RESP;
                end
                else if (!scan_vld_reg && (scan_issue_reg >= act_len))
                begin
                    pc_next     = act_len;
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_item_next.status          = status_next;
        res_item_next.out_valid       = r_ov;
        res_item_next.out_byte        = r_ob;
        res_item_next.input_taken     = r_it;
        res_item_next.program_counter = pc_next;

        res_valid_next = res_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ptr_reg        <= '0;
            pc_reg         <= '0;
            depth_reg      <= '0;
            status_reg     <= ST_RUNNING;
            fill_reg       <= '0;
            plen_reg       <= '0;
            scan_issue_reg <= '0;
            scan_vld_reg   <= 1'b0;
            nest_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pc_reg         <= pc_next;
            depth_reg      <= depth_next;
            status_reg     <= status_next;
            fill_reg       <= fill_next;
            scan_issue_reg <= scan_issue_next;
            scan_vld_reg   <= scan_vld_next;
            nest_reg       <= nest_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_chk_reg <= scan_chk_next;
        if (res_load)
        begin
            res_item_reg <= res_item_next;
        end
    end

    a_ptr_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        FILL_W'(ptr_reg) <= fill_reg)
        else $error("cell pointer beyond fill count");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("loop depth beyond stack size");

    a_scan_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (status_reg == ST_RUNNING))
        else $error("bracket scan while halted");

    a_exec_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && res_free) |=> (state_reg == S_IDLE || state_reg == S_SCAN))
        else $error("execute did not complete with free result slot");

endmodule
